FILE: hw/rtl/lsps_pkg.sv
package lsps_pkg;

  // Sensor lanes, one per reading in a scan.
  localparam int NUM_LANES = 8;
  localparam int SENSOR_W  = 8;

  // Fixed-point constants of the steering law.
  localparam logic signed [15:0] EDGE_ERR   = 16'sd3200;
  localparam logic signed [15:0] LOST_ERR   = 16'sd4480;
  localparam int                 GAIN_SHIFT = 10;
  localparam int                 DUTY_SHIFT = 7;

  // Width of the weighted sum before saturation (8 terms of 16 bits).
  localparam int SUM_W = 19;

  // Register reset values.
  localparam logic [15:0] GAIN_P_RST    = 16'd1024;
  localparam logic [15:0] GAIN_I_RST    = 16'd0;
  localparam logic [15:0] GAIN_D_RST    = 16'd1;
  localparam logic [31:0] WEIGHTS_L_RST = 32'hFFFD_F9F1;
  localparam logic [31:0] WEIGHTS_H_RST = 32'h0F07_0301;
  localparam logic [7:0]  THRESH_RST    = 8'd210;
  localparam logic [15:0] STRAIGHT_RST  = 16'd1500;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_WEIGHTS_L = 3'd3,
    CFG_WEIGHTS_H = 3'd4,
    CFG_THRESH    = 3'd5,
    CFG_STRAIGHT  = 3'd6
  } cfg_idx_t;

  // What one sensor lane found.
  typedef struct packed {
    logic        dark;
    logic        below;
    logic [15:0] contrib;
  } lane_t;

  // Error before the line-lost resolution, from the merging stage.
  typedef struct packed {
    logic [15:0] e_pre;
    logic        clr;
    logic        lost;
  } pre_t;

  // Load enables of the controller stages.
  typedef struct packed {
    logic err;
    logic acc;
    logic mul;
    logic sum;
    logic res;
  } load_t;

  // Result item, position error in the lowest bits.
  typedef struct packed {
    logic [7:0]  scans_since_line;
    logic [15:0] servo_duty;
    logic [15:0] pid_value;
    logic [15:0] position_error;
  } res_t;

endpackage

FILE: hw/rtl/lsps_lane.sv
module lsps_lane (
  input  logic                            clk,
  input  logic                            load,
  input  logic [lsps_pkg::SENSOR_W-1:0]   sensor,
  input  logic [lsps_pkg::SENSOR_W-1:0]   threshold,
  input  logic [7:0]                      weight,
  output lsps_pkg::lane_t                 lane_r
);
  import lsps_pkg::*;

  lane_t lane_nxt;

  // Compare against the threshold and scale the weight by 128.
  always_comb begin
    lane_nxt.dark    = sensor > threshold;
    lane_nxt.below   = sensor < threshold;
    lane_nxt.contrib = lane_nxt.dark ? {weight[7], weight, 7'b0} : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= lane_nxt;
    end
  end

endmodule

FILE: hw/rtl/lsps_merge.sv
module lsps_merge (
  input  logic                  clk,
  input  logic                  load,
  input  lsps_pkg::lane_t       lanes [lsps_pkg::NUM_LANES],
  output lsps_pkg::pre_t        pre_r
);
  import lsps_pkg::*;

  logic signed [SUM_W-1:0] lvl1 [NUM_LANES/2];
  logic signed [SUM_W-1:0] lvl2 [NUM_LANES/4];
  logic signed [SUM_W-1:0] total;
  logic signed [15:0]      wsat;
  logic                    any_dark;
  pre_t                    pre_nxt;

  // Adder tree over the lane contributions.
  always_comb begin
    for (int i = 0; i < NUM_LANES/2; i++) begin
      lvl1[i] = SUM_W'($signed(lanes[2*i].contrib)) + SUM_W'($signed(lanes[2*i+1].contrib));
    end
    for (int i = 0; i < NUM_LANES/4; i++) begin
      lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    end
    total = lvl2[0] + lvl2[1];
    any_dark = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      any_dark = any_dark | lanes[i].dark;
    end
  end

  // Saturate the weighted sum to 16 bits.
  always_comb begin
    if (total > SUM_W'(32767)) begin
      wsat = 16'sd32767;
    end else if (total < -SUM_W'(32768)) begin
      wsat = -16'sd32768;
    end else begin
      wsat = total[15:0];
    end
  end

  // Edge-only cases first, right edge ahead of left, then the weighted sum.
  always_comb begin
    priority if (lanes[7].dark && lanes[6].below) begin
      pre_nxt.e_pre = EDGE_ERR;
      pre_nxt.clr   = 1'b1;
      pre_nxt.lost  = 1'b0;
    end else if (lanes[0].dark && lanes[1].below) begin
      pre_nxt.e_pre = -EDGE_ERR;
      pre_nxt.clr   = 1'b1;
      pre_nxt.lost  = 1'b0;
    end else begin
      pre_nxt.e_pre = wsat;
      pre_nxt.clr   = any_dark;
      pre_nxt.lost  = (wsat == 16'sd0) && lanes[3].below && lanes[4].below;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pre_r <= pre_nxt;
    end
  end

endmodule

FILE: hw/rtl/lsps_pid.sv
module lsps_pid (
  input  logic               clk,
  input  logic               rst_n,
  input  lsps_pkg::load_t    ld,
  input  lsps_pkg::pre_t     pre,
  input  logic signed [15:0] gain_p,
  input  logic signed [15:0] gain_i,
  input  logic signed [15:0] gain_d,
  input  logic [15:0]        straight_duty,
  output lsps_pkg::res_t     res_r
);
  import lsps_pkg::*;

  // Controller state.
  logic signed [15:0] last_error_r, last_error_nxt;
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic [7:0]         lost_count_r, lost_count_nxt;

  // Stage payloads.
  logic signed [15:0] e_c_r, e_d_r, e_e_r, e_f_r;
  logic signed [16:0] diff_c_r, diff_d_r, diff_nxt;
  logic [7:0]         cnt_c_r, cnt_d_r, cnt_e_r, cnt_f_r;
  logic signed [31:0] p_e_r, p_nxt;
  logic signed [47:0] i_e_r, i_nxt;
  logic signed [32:0] d_e_r, d_nxt;
  logic signed [15:0] pid_f_r, pid_nxt;
  res_t               res_nxt;

  // Error stage: resolve a lost line against the previous error.
  logic [7:0] cnt_base;
  always_comb begin
    last_error_nxt = pre.e_pre;
    if (pre.lost) begin
      priority if (!last_error_r[15] && last_error_r < LOST_ERR) begin
        last_error_nxt = LOST_ERR;
      end else if (last_error_r[15] && last_error_r > -LOST_ERR) begin
        last_error_nxt = -LOST_ERR;
      end else begin
        last_error_nxt = last_error_r;
      end
    end
    diff_nxt = $signed({last_error_nxt[15], last_error_nxt})
             - $signed({last_error_r[15], last_error_r});
    cnt_base       = pre.clr ? 8'd0 : lost_count_r;
    lost_count_nxt = pre.lost ? cnt_base + 8'd1 : cnt_base;
  end

  // Accumulate stage: running error sum, saturated to 32 bits.
  logic signed [32:0] acc_wide;
  always_comb begin
    acc_wide = 33'(e_c_r) + 33'(error_sum_r);
    if (acc_wide[32] != acc_wide[31]) begin
      error_sum_nxt = acc_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      error_sum_nxt = acc_wide[31:0];
    end
  end

  // Multiply stage: one product per term.
  always_comb begin
    p_nxt = gain_p * e_d_r;
    i_nxt = gain_i * error_sum_r;
    d_nxt = gain_d * diff_d_r;
  end

  // Sum stage: floor shifts, sum of terms, saturation to 16 bits.
  logic signed [21:0] p_sh;
  logic signed [37:0] i_sh;
  logic signed [22:0] d_sh;
  logic signed [38:0] pid_wide;
  always_comb begin
    p_sh     = 22'(p_e_r >>> GAIN_SHIFT);
    i_sh     = 38'(i_e_r >>> GAIN_SHIFT);
    d_sh     = 23'(d_e_r >>> GAIN_SHIFT);
    pid_wide = 39'(p_sh) + 39'(i_sh) + 39'(d_sh);
    if (pid_wide > 39'sd32767) begin
      pid_nxt = 16'sd32767;
    end else if (pid_wide < -39'sd32768) begin
      pid_nxt = -16'sd32768;
    end else begin
      pid_nxt = pid_wide[15:0];
    end
  end

  // Duty stage: straight duty minus ten steps per 128 of pid, clamped.
  logic signed [8:0]  pid_q;
  logic signed [12:0] pid_ten;
  logic signed [17:0] duty_wide;
  always_comb begin
    pid_q     = 9'(pid_f_r >>> DUTY_SHIFT);
    pid_ten   = (13'(pid_q) <<< 3) + (13'(pid_q) <<< 1);
    duty_wide = $signed({2'b00, straight_duty}) - 18'(pid_ten);
    if (duty_wide < 18'sd0) begin
      res_nxt.servo_duty = 16'd0;
    end else if (duty_wide > 18'sd65535) begin
      res_nxt.servo_duty = 16'hFFFF;
    end else begin
      res_nxt.servo_duty = duty_wide[15:0];
    end
    res_nxt.position_error   = e_f_r;
    res_nxt.pid_value        = pid_f_r;
    res_nxt.scans_since_line = cnt_f_r;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      lost_count_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (ld.err) begin
        last_error_r <= last_error_nxt;
        lost_count_r <= lost_count_nxt;
      end
      if (ld.acc) begin
        error_sum_r <= error_sum_nxt;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (ld.err) begin
      e_c_r    <= last_error_nxt;
      diff_c_r <= diff_nxt;
      cnt_c_r  <= lost_count_nxt;
    end
    if (ld.acc) begin
      e_d_r    <= e_c_r;
      diff_d_r <= diff_c_r;
      cnt_d_r  <= cnt_c_r;
    end
    if (ld.mul) begin
      p_e_r   <= p_nxt;
      i_e_r   <= i_nxt;
      d_e_r   <= d_nxt;
      e_e_r   <= e_d_r;
      cnt_e_r <= cnt_d_r;
    end
    if (ld.sum) begin
      pid_f_r <= pid_nxt;
      e_f_r   <= e_e_r;
      cnt_f_r <= cnt_e_r;
    end
    if (ld.res) begin
      res_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The running sum only moves when an item enters the accumulate stage.
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld.acc |=> $stable(error_sum_r))
    else $error("error sum changed without an item");

  // A lost line never resolves to a zero error.
  a_lost_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ld.err && pre.lost |=> e_c_r != 16'sd0)
    else $error("lost line gave zero error");

  // A lost scan with no dark sensor advances the scan count by one.
  a_lost_count: assert property (@(posedge clk) disable iff (!rst_n)
    ld.err && pre.lost && !pre.clr |=> lost_count_r == 8'($past(lost_count_r) + 8'd1))
    else $error("scan count did not advance");
`endif

endmodule

FILE: hw/rtl/line_sensor_pid_steering.sv
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    in_tdata: sensor_0..sensor_7, 8 bits each
// out_      master     out_tvalid/out_tready  out_tdata: error, pid, duty, scan count
// cfg_      slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Seven-stage pipeline: sensor lanes, merge, error, accumulate, multiply, sum,
// duty. One item per cycle sustained while out_tready stays high; an accepted
// item moves through the stages in that order before its result is offered.
// Each state loop closes within its own stage: last error and scan count in the
// error stage, the running sum in the accumulate stage.
// Synchronous active-low reset clears the stage valid bits and the state and
// presets the configuration registers. A full stage holds while the next one
// cannot take its item; empty stages fill up; in_tready drops only with all full.
module line_sensor_pid_steering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sensor_0 [7:0] up to sensor_7 [63:56]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // position_error, pid_value, servo_duty, scans_since_line
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lsps_pkg::*;

  localparam int NSTG = 7;

  // Configuration registers.
  logic [15:0] gain_p_r, gain_i_r, gain_d_r, straight_r;
  logic [31:0] weights_l_r, weights_h_r;
  logic [7:0]  thresh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      weights_l_r <= WEIGHTS_L_RST;
      weights_h_r <= WEIGHTS_H_RST;
      thresh_r    <= THRESH_RST;
      straight_r  <= STRAIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:    gain_p_r    <= cfg_data[15:0];
        CFG_GAIN_I:    gain_i_r    <= cfg_data[15:0];
        CFG_GAIN_D:    gain_d_r    <= cfg_data[15:0];
        CFG_WEIGHTS_L: weights_l_r <= cfg_data;
        CFG_WEIGHTS_H: weights_h_r <= cfg_data;
        CFG_THRESH:    thresh_r    <= cfg_data[7:0];
        CFG_STRAIGHT:  straight_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain back from the output.
  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-1:0] rdy, ld, leave;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0] = in_tvalid && rdy[0];
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = v_r[k-1] && rdy[k];
    end
    for (int k = 0; k < NSTG-1; k++) begin
      leave[k] = ld[k+1];
    end
    leave[NSTG-1] = v_r[NSTG-1] && out_tready;
    for (int k = 0; k < NSTG; k++) begin
      v_nxt[k] = ld[k] || (v_r[k] && !leave[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NSTG-1];

  // Sensor lanes.
  lane_t lanes [NUM_LANES];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    logic [7:0] weight;
    if (k < NUM_LANES/2) begin : g_low
      assign weight = weights_l_r[8*k +: 8];
    end else begin : g_high
      assign weight = weights_h_r[8*(k-NUM_LANES/2) +: 8];
    end
    lsps_lane u_lane (
      .clk       (clk),
      .load      (ld[0]),
      .sensor    (in_tdata[SENSOR_W*k +: SENSOR_W]),
      .threshold (thresh_r),
      .weight    (weight),
      .lane_r    (lanes[k])
    );
  end

  // Merge of the lane results.
  pre_t pre;

  lsps_merge u_merge (
    .clk   (clk),
    .load  (ld[1]),
    .lanes (lanes),
    .pre_r (pre)
  );

  // Controller stages.
  load_t pid_ld;
  res_t  res;

  assign pid_ld.err = ld[2];
  assign pid_ld.acc = ld[3];
  assign pid_ld.mul = ld[4];
  assign pid_ld.sum = ld[5];
  assign pid_ld.res = ld[6];

  lsps_pid u_pid (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (pid_ld),
    .pre           (pre),
    .gain_p        (gain_p_r),
    .gain_i        (gain_i_r),
    .gain_d        (gain_d_r),
    .straight_duty (straight_r),
    .res_r         (res)
  );

  assign out_tdata = res;

`ifndef ASSERT_OFF
  // A full stage whose successor cannot take its item keeps it.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !rdy[3] |=> v_r[2])
    else $error("stage dropped an item");

  // Input is refused only when every stage holds an item.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled with an empty stage");

  // A result never appears out of an empty pipeline.
  a_no_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) |=> !out_tvalid)
    else $error("result appeared from an empty pipeline");
`endif

endmodule

FILE: test/testbench.sv
module testbench;
  import lsps_pkg::*;

  // Deepest the pipeline gets, and how long the run may take at most.
  localparam int         PIPE_DEPTH  = 7;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] CFG_UNUSED  = 3'd7;
  localparam longint     SUM_MAX     = 64'sd2147483647;
  localparam longint     SUM_MIN     = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // sensor_0 [7:0] up to sensor_7 [63:56]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // position_error, pid_value, servo_duty, scans_since_line
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Our copy of the registers and of the steering state.
  logic signed [15:0] kp, ki, kd;
  logic [31:0]        wlo, whi;
  logic [7:0]         thr;
  logic [15:0]        straight;
  longint             prev_error, error_total;
  logic [7:0]         scans_lost;

  res_t expected_steering [$];
  int   sender_gap_pct, sink_stall_pct;
  int   cycle_count, mismatches, results_seen, scans_sent, settings_used;

  line_sensor_pid_steering uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register and state values that follow reset.
  task automatic reset_model();
    kp          = GAIN_P_RST;
    ki          = GAIN_I_RST;
    kd          = GAIN_D_RST;
    wlo         = WEIGHTS_L_RST;
    whi         = WEIGHTS_H_RST;
    thr         = THRESH_RST;
    straight    = STRAIGHT_RST;
    prev_error  = 0;
    error_total = 0;
    scans_lost  = '0;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Steering result for one scan; advances the state as the block does.
  function automatic res_t predict_steering(input logic [63:0] scan);
    logic [7:0] s [8];
    byte        w;
    longint     e, p, iv, d, pid, duty;
    res_t       r;
    for (int k = 0; k < 8; k++) s[k] = scan[8*k +: 8];
    e = 0;
    // The right edge is tested before the left one.
    if (s[7] > thr && s[6] < thr) begin
      e = EDGE_ERR;
      scans_lost = '0;
    end else if (s[0] > thr && s[1] < thr) begin
      e = -EDGE_ERR;
      scans_lost = '0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (s[k] > thr) begin
          w = (k < 4) ? wlo[8*k +: 8] : whi[8*(k-4) +: 8];
          e += 128 * w;
          scans_lost = '0;
        end
      end
      e = clamp(e, -32768, 32767);
      // Line lost: count the scan and steer hard or hold the last error.
      if (e == 0 && s[3] < thr && s[4] < thr) begin
        scans_lost++;
        if (prev_error >= 0 && prev_error < LOST_ERR) e = LOST_ERR;
        else if (prev_error < 0 && prev_error > -LOST_ERR) e = -LOST_ERR;
        else e = prev_error;
      end
    end
    p           = (kp * e) >>> GAIN_SHIFT;
    error_total = clamp(error_total + e, SUM_MIN, SUM_MAX);
    iv          = (ki * error_total) >>> GAIN_SHIFT;
    d           = (kd * (e - prev_error)) >>> GAIN_SHIFT;
    pid         = clamp(p + iv + d, -32768, 32767);
    prev_error  = e;
    duty        = clamp(longint'(straight) - 10 * (pid >>> DUTY_SHIFT), 0, 65535);
    r.position_error   = e[15:0];
    r.pid_value        = pid[15:0];
    r.servo_duty       = duty[15:0];
    r.scans_since_line = scans_lost;
    return r;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      CFG_GAIN_P:    kp       = value[15:0];
      CFG_GAIN_I:    ki       = value[15:0];
      CFG_GAIN_D:    kd       = value[15:0];
      CFG_WEIGHTS_L: wlo      = value;
      CFG_WEIGHTS_H: whi      = value;
      CFG_THRESH:    thr      = value[7:0];
      CFG_STRAIGHT:  straight = value[15:0];
      default: ;
    endcase
  endfunction

  // All tasks below start and end just after a falling edge.
  task automatic send_scan(input logic [63:0] scan);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = scan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_steering.push_back(predict_steering(scan));
    scans_sent++;
    @(negedge clk);
  endtask

  // Hold the input back until every result is in and the pipeline is empty.
  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (expected_steering.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [7:0] th,
                               input logic [15:0] duty);
    wait_for_results();
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_WEIGHTS_L, lo);
    write_reg(CFG_WEIGHTS_H, hi);
    write_reg(CFG_THRESH, th);
    write_reg(CFG_STRAIGHT, duty);
    settings_used++;
  endtask

  // Mostly small gains, now and then the full range; weights small half the time.
  task automatic load_random_settings();
    logic [15:0] g [3];
    logic [31:0] wt [2];
    logic [7:0]  th;
    logic [15:0] duty;
    for (int n = 0; n < 3; n++)
      g[n] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096)) - 16'd2048;
    for (int n = 0; n < 2; n++) begin
      wt[n] = $urandom;
      if ($urandom_range(1) == 0)
        for (int b = 0; b < 4; b++) wt[n][8*b +: 8] = 8'($urandom_range(32)) - 8'd16;
    end
    case ($urandom_range(7))
      0:       th = 8'd0;
      1:       th = 8'd255;
      default: th = 8'($urandom_range(250, 40));
    endcase
    duty = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    load_settings(g[0], g[1], g[2], wt[0], wt[1], th, duty);
  endtask

  // A dark band of one to three sensors, a lost line, or plain noise;
  // now and then a reading sits exactly on the threshold.
  function automatic logic [63:0] random_scan();
    logic [63:0] scan;
    int          kind, first, last;
    kind = $urandom_range(9);
    if (kind < 2) return {$urandom, $urandom};
    first = $urandom_range(7);
    last  = first + $urandom_range(2);
    if (last > 7) last = 7;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(11) == 0)
        scan[8*k +: 8] = thr;
      else if (kind > 2 && k >= first && k <= last)
        scan[8*k +: 8] = (thr == 8'hFF) ? thr : 8'($urandom_range(255, thr + 1));
      else
        scan[8*k +: 8] = (thr == 8'h00) ? 8'h00 : 8'($urandom_range(thr - 1, 0));
    end
    return scan;
  endfunction

  // Hand-picked scans under the reset settings, threshold 210.
  task automatic test_reset_defaults();
    logic [63:0] scans [$];
    scans = '{
      64'h0000_0000_0000_0000,   // line lost from a zero error
      64'h0000_0000_0000_0000,   // lost again, error held
      64'hFF00_0000_0000_0000,   // right edge only
      64'h0000_0000_0000_00FF,   // left edge only
      64'h0000_0000_0000_0000,   // lost after a left turn
      64'h0000_0000_0000_0000,   // held at the negative limit
      64'hFF00_0000_0000_00FF,   // both edges, right one wins
      64'hFFFF_FFFF_FFFF_FFFF,   // all dark, weights cancel, centre dark
      64'hFFD2_0000_0000_0000,   // edge neighbour on the threshold
      64'h0000_FF00_00FF_0000,   // cancelling weights with a light centre
      64'hD2D2_D2D2_D2D2_D2D2,   // every reading on the threshold
      64'h0000_0000_D200_0000,   // centre reading on the threshold
      64'h0000_0000_0000_0000,
      64'h0000_0000_FF00_0000,   // left centre
      64'h0000_00FF_0000_0000,   // right centre
      64'h0000_0000_0000_D2FF,   // left edge with neighbour on the threshold
      64'hFFFF_0000_0000_0000,
      64'h0000_0000_0000_FFFF,
      64'hD3D1_0000_0000_0000,   // edge by the narrowest margin
      64'h0000_0000_0000_0000,
      64'h5555_AAAA_5555_AAAA,
      64'hD3D3_D3D3_D3D3_D3D3
    };
    foreach (scans[n]) begin
      // Let the pipeline run dry once in the middle.
      if (n == 10) wait_for_results();
      send_scan(scans[n]);
    end
  endtask

  // A write to an index past the register list must change nothing.
  task automatic test_unused_index();
    wait_for_results();
    write_reg(CFG_UNUSED, $urandom);
    send_scan(64'h0000_0000_0000_0000);
    send_scan(64'hFF00_0000_0000_0000);
    repeat (4) send_scan(random_scan());
  endtask

  task automatic test_setting_extremes();
    for (int n = 0; n < 3; n++) begin
      case (n)
        0: load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7F7F_7F7F, 32'h7F7F_7F7F,
                         8'd0, 16'hFFFF);
        1: load_settings(16'h8000, 16'h8000, 16'h8000, 32'h8080_8080, 32'h8080_8080,
                         8'd255, 16'h0000);
        default: load_settings(16'h8000, 16'h7FFF, 16'h0000, 32'h8080_7F7F,
                               32'h7F7F_8080, 8'd254, 16'h0000);
      endcase
      send_scan('1);
      send_scan('0);
      repeat (20) send_scan(random_scan());
      send_scan('1);
    end
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) load_random_settings();
      send_scan(random_scan());
    end
  endtask

  // More lost scans in a row than the counter can hold.
  task automatic test_lost_count_wrap();
    load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, WEIGHTS_L_RST, WEIGHTS_H_RST,
                  8'd128, STRAIGHT_RST);
    repeat (300) send_scan('1 >> 64);
  endtask

  // Largest error every scan under the strongest integral gain, then the
  // opposite error, so the integral alone drives the terms into both limits.
  task automatic test_integral_windup();
    load_settings(16'd0, 16'h7FFF, 16'd0, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 8'd0, STRAIGHT_RST);
    repeat (40) send_scan('1);
    load_settings(16'd0, 16'h7FFF, 16'd0, 32'h8080_8080, 32'h8080_8080, 8'd0, STRAIGHT_RST);
    repeat (80) send_scan('1);
  endtask

  // The receiver stalls at random on its own.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= sink_stall_pct);

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("Result %0d: %s expected %h, got %h", results_seen, what, want, got);
      mismatches++;
    end
  endtask

  // Each result against the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata);
      results_seen++;
      if (expected_steering.size() == 0) begin
        if (mismatches < 10)
          $display("Result %0d arrived with none expected: %h", results_seen, out_tdata);
        mismatches++;
      end else begin
        want = expected_steering.pop_front();
        compare_field("position_error", want.position_error, got.position_error);
        compare_field("pid_value", want.pid_value, got.pid_value);
        compare_field("servo_duty", want.servo_duty, got.servo_duty);
        compare_field("scans_since_line", 16'(want.scans_since_line),
                      16'(got.scans_since_line));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Stopped after %0d cycles, %0d results outstanding.", cycle_count,
               expected_steering.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    reset_model();
    sender_gap_pct = 23;
    sink_stall_pct = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_unused_index();
    test_random_traffic(400);

    sender_gap_pct = 88;
    sink_stall_pct = 23;
    test_setting_extremes();
    test_random_traffic(400);

    sender_gap_pct = 0;
    sink_stall_pct = 0;
    test_lost_count_wrap();
    test_random_traffic(250);
    test_integral_windup();

    wait_for_results();
    $display("Steered %0d scans under %0d register settings and checked %0d results,",
             scans_sent, settings_used, results_seen);
    $display("including edge, lost-line, counter wrap and integral windup cases.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches in total.", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
